// ----- sv/imu_bias_smooth_scale_defines.svh -----
// Assertion macros shared by the IMU bias/smoothing block checkers
`ifndef IMU_BIAS_SMOOTH_SCALE_DEFINES_SVH
`define IMU_BIAS_SMOOTH_SCALE_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off while in reset
`define IBSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk, off while in reset
`define IBSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ibss_pkg.sv -----
// Types and constants for the IMU bias removal, smoothing and scaling block
package ibss_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int NUM_AXES      = 6;
    localparam int AXIS_W        = 3;
    localparam int RAW_W         = 16;
    localparam int DIF_W         = RAW_W + 1;             // raw minus bias
    localparam int S_W           = FRACTION_BITS + 18;    // smoother state
    localparam int D_W           = S_W + 1;               // x minus state
    localparam int B_W           = 17;                    // unsigned multiplier operand
    localparam int P_W           = D_W + B_W + 1;         // signed product
    localparam int OUT_W         = 32;
    localparam int BIAS_W        = 48;
    localparam int WGT_W         = 17;
    localparam int GAIN_W        = 32;
    localparam int APB_DW        = 64;
    localparam int APB_AW        = 6;
    localparam int REG_W         = 3;

    localparam logic [AXIS_W-1:0] AXIS_LAST  = AXIS_W'(NUM_AXES - 1);
    localparam logic [AXIS_W-1:0] AXIS_GYRO0 = AXIS_W'(3);

    localparam logic [WGT_W-1:0] ALPHA_ONE = WGT_W'(65536);

    // register map, index = paddr[5:3]
    localparam logic [REG_W-1:0] REG_ACCEL_BIAS = 3'd0;
    localparam logic [REG_W-1:0] REG_GYRO_BIAS  = 3'd1;
    localparam logic [REG_W-1:0] REG_WEIGHT     = 3'd2;
    localparam logic [REG_W-1:0] REG_ACCEL_GAIN = 3'd3;
    localparam logic [REG_W-1:0] REG_GYRO_GAIN  = 3'd4;

    localparam logic [WGT_W-1:0]  WEIGHT_RST     = WGT_W'(9830);
    localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = GAIN_W'(20573061);
    localparam logic [GAIN_W-1:0] GYRO_GAIN_RST  = GAIN_W'(4575214);

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_accel_x;
        logic signed [RAW_W-1:0] raw_accel_y;
        logic signed [RAW_W-1:0] raw_accel_z;
        logic signed [RAW_W-1:0] raw_gyro_x;
        logic signed [RAW_W-1:0] raw_gyro_y;
        logic signed [RAW_W-1:0] raw_gyro_z;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] lin_accel_x;
        logic signed [OUT_W-1:0] lin_accel_y;
        logic signed [OUT_W-1:0] lin_accel_z;
        logic signed [OUT_W-1:0] ang_rate_x;
        logic signed [OUT_W-1:0] ang_rate_y;
        logic signed [OUT_W-1:0] ang_rate_z;
    } t_out;

    typedef struct packed {
        logic [BIAS_W-1:0] accel_bias;
        logic [BIAS_W-1:0] gyro_bias;
        logic [WGT_W-1:0]  weight;
        logic [GAIN_W-1:0] accel_gain;
        logic [GAIN_W-1:0] gyro_gain;
    } t_cfg;

endpackage

// ----- sv/ibss_cfg.sv -----
// APB register file holding biases, smoothing weight and gains
module ibss_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ibss_pkg::APB_AW-1:0] paddr,
    input  logic [ibss_pkg::APB_DW-1:0] pwdata,
    output logic [ibss_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output ibss_pkg::t_cfg             o_cfg
);
    import ibss_pkg::*;

    t_cfg             r_cfg;
    logic [REG_W-1:0] reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:3];
    assign wr_en   = psel & penable & pwrite & pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_bias <= '0;
            r_cfg.gyro_bias  <= '0;
            r_cfg.weight     <= WEIGHT_RST;
            r_cfg.accel_gain <= ACCEL_GAIN_RST;
            r_cfg.gyro_gain  <= GYRO_GAIN_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ACCEL_BIAS: r_cfg.accel_bias <= pwdata[BIAS_W-1:0];
                REG_GYRO_BIAS:  r_cfg.gyro_bias  <= pwdata[BIAS_W-1:0];
                REG_WEIGHT:     r_cfg.weight     <= pwdata[WGT_W-1:0];
                REG_ACCEL_GAIN: r_cfg.accel_gain <= pwdata[GAIN_W-1:0];
                REG_GYRO_GAIN:  r_cfg.gyro_gain  <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ACCEL_BIAS: prdata = APB_DW'(r_cfg.accel_bias);
            REG_GYRO_BIAS:  prdata = APB_DW'(r_cfg.gyro_bias);
            REG_WEIGHT:     prdata = APB_DW'(r_cfg.weight);
            REG_ACCEL_GAIN: prdata = APB_DW'(r_cfg.accel_gain);
            REG_GYRO_GAIN:  prdata = APB_DW'(r_cfg.gyro_gain);
            default:        prdata = '0;
        endcase
    end

endmodule

// ----- sv/ibss_mac.sv -----
// Shared signed-by-unsigned multiplier with registered product
module ibss_mac (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [ibss_pkg::D_W-1:0]   i_a,
    input  logic        [ibss_pkg::B_W-1:0]   i_b,
    output logic signed [ibss_pkg::P_W-1:0]   o_prod
);
    import ibss_pkg::*;

    logic signed [P_W-1:0] a_ext;
    logic signed [P_W-1:0] b_ext;
    logic signed [P_W-1:0] r_prod;
    logic signed [P_W-1:0] n_prod;

    assign a_ext  = P_W'(i_a);
    assign b_ext  = P_W'($signed({1'b0, i_b}));
    assign n_prod = a_ext * b_ext;
    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

endmodule

// ----- sv/ibss_seq.sv -----
// Per-axis sequencer: bias removal, smoothing update and output scaling
module ibss_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ibss_pkg::t_cfg  i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ibss_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output ibss_pkg::t_out  o_out_data
);
    import ibss_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIFF = 3'd1;
    localparam logic [2:0] S_MULA = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_LO   = 3'd4;
    localparam logic [2:0] S_HI   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;
    localparam logic [2:0] S_HOLD = 3'd7;

    localparam int TOP_W = P_W - FRACTION_BITS - OUT_W + 1;

    logic [2:0]          r_state, n_state;
    logic [AXIS_W-1:0]   r_axis, n_axis;
    logic                r_primed, n_primed;
    logic                r_out_valid, n_out_valid;
    t_in                 r_raw;
    t_out                r_out_data;
    logic signed [D_W-1:0]   r_diff;
    logic signed [P_W-1:0]   r_acc;
    logic signed [S_W-1:0]   r_s   [NUM_AXES];
    logic signed [OUT_W-1:0] r_res [NUM_AXES];

    logic                    accept;
    logic                    load_out;
    logic                    is_gyro;
    logic signed [RAW_W-1:0] raw_cur;
    logic [BIAS_W-1:0]       bias_word;
    logic signed [RAW_W-1:0] bias_cur;
    logic signed [DIF_W-1:0] d_val;
    logic signed [S_W-1:0]   x_val;
    logic signed [S_W-1:0]   s_cur;
    logic signed [D_W-1:0]   diff;
    logic [WGT_W-1:0]        alpha;
    logic [GAIN_W-1:0]       gain;
    logic                    mac_en;
    logic signed [D_W-1:0]   mac_a;
    logic [B_W-1:0]          mac_b;
    logic signed [P_W-1:0]   prod;
    logic signed [S_W-1:0]   s_upd;
    logic signed [P_W-1:0]   sum;
    logic [TOP_W-1:0]        sum_top;
    logic signed [OUT_W-1:0] sat_val;

    assign accept      = i_in_valid & ~o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign load_out    = (r_state == S_HOLD) & (~r_out_valid | ~i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // operand selection for the current axis
    assign is_gyro = (r_axis >= AXIS_GYRO0);
    assign bias_word = is_gyro ? i_cfg.gyro_bias : i_cfg.accel_bias;

    always_comb begin
        unique case (r_axis)
            3'd0:    raw_cur = r_raw.raw_accel_x;
            3'd1:    raw_cur = r_raw.raw_accel_y;
            3'd2:    raw_cur = r_raw.raw_accel_z;
            3'd3:    raw_cur = r_raw.raw_gyro_x;
            3'd4:    raw_cur = r_raw.raw_gyro_y;
            default: raw_cur = r_raw.raw_gyro_z;
        endcase
    end

    always_comb begin
        unique case (r_axis)
            3'd0, 3'd3: bias_cur = $signed(bias_word[15:0]);
            3'd1, 3'd4: bias_cur = $signed(bias_word[31:16]);
            default:    bias_cur = $signed(bias_word[47:32]);
        endcase
    end

    assign d_val = DIF_W'(raw_cur) - DIF_W'(bias_cur);
    assign x_val = S_W'($signed({d_val, {FRACTION_BITS{1'b0}}}));
    assign s_cur = r_s[r_axis];
    assign diff  = D_W'(x_val) - D_W'(s_cur);

    // weights above one act as one
    assign alpha = i_cfg.weight[WGT_W-1] ? ALPHA_ONE : i_cfg.weight;
    assign gain  = is_gyro ? i_cfg.gyro_gain : i_cfg.accel_gain;

    assign mac_en = (r_state == S_MULA) | (r_state == S_LO) | (r_state == S_HI);
    assign mac_a  = (r_state == S_MULA) ? r_diff : D_W'(s_cur);

    always_comb begin
        unique case (r_state)
            S_MULA:  mac_b = alpha;
            S_LO:    mac_b = {1'b0, gain[15:0]};
            default: mac_b = {1'b0, gain[31:16]};
        endcase
    end

    ibss_mac u_mac (
        .i_clk  (i_clk),
        .i_en   (mac_en),
        .i_a    (mac_a),
        .i_b    (mac_b),
        .o_prod (prod)
    );

    // state always fits; wrap-around in the truncated add is harmless
    assign s_upd = s_cur + $signed(prod[S_W+15:16]);

    // hi + floor(lo / 2^16), then floor by the fraction bits and clip
    assign sum     = prod + r_acc;
    assign sum_top = sum[P_W-1:FRACTION_BITS+OUT_W-1];

    always_comb begin
        if ((&sum_top) | ~(|sum_top)) begin
            sat_val = $signed(sum[FRACTION_BITS+OUT_W-1:FRACTION_BITS]);
        end else if (sum[P_W-1]) begin
            sat_val = $signed({1'b1, {(OUT_W-1){1'b0}}});
        end else begin
            sat_val = $signed({1'b0, {(OUT_W-1){1'b1}}});
        end
    end

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_primed    = r_primed;
        n_out_valid = r_out_valid;
        if (r_out_valid & ~i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_axis  = '0;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: n_state = r_primed ? S_MULA : S_LO;
            S_MULA: n_state = S_UPD;
            S_UPD:  n_state = S_LO;
            S_LO:   n_state = S_HI;
            S_HI:   n_state = S_OUT;
            S_OUT: begin
                if (r_axis == AXIS_LAST) begin
                    n_state = S_HOLD;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_DIFF;
                end
            end
            S_HOLD: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_primed    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_primed    <= n_primed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw <= i_in_data;
        end
        if (r_state == S_DIFF) begin
            if (r_primed) begin
                r_diff <= diff;
            end else begin
                r_s[r_axis] <= x_val;
            end
        end
        if (r_state == S_UPD) begin
            r_s[r_axis] <= s_upd;
        end
        if (r_state == S_HI) begin
            r_acc <= prod >>> 16;
        end
        if (r_state == S_OUT) begin
            r_res[r_axis] <= sat_val;
        end
        if (load_out) begin
            r_out_data.lin_accel_x <= r_res[0];
            r_out_data.lin_accel_y <= r_res[1];
            r_out_data.lin_accel_z <= r_res[2];
            r_out_data.ang_rate_x  <= r_res[3];
            r_out_data.ang_rate_y  <= r_res[4];
            r_out_data.ang_rate_z  <= r_res[5];
        end
    end

endmodule

// ----- sv/imu_bias_smooth_scale.sv -----
// One sample at a time: a new input is taken only after the previous result has been loaded.
// Six axes in turn through one multiplier; per axis: difference, smoothing product, state
// update, two gain halves and the final clip; the first sample after reset skips the smoothing.
// An output held by stall blocks the next result hand-off, not the wait for it.
// Reset (i_rst_n low, synchronous): registers back to defaults, smoother unprimed, output empty.
// Top level: ties the register file to the per-axis sequencer
module imu_bias_smooth_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ibss_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ibss_pkg::t_out              o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ibss_pkg::APB_AW-1:0] paddr,
    input  logic [ibss_pkg::APB_DW-1:0] pwdata,
    output logic [ibss_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import ibss_pkg::*;

    t_cfg cfg;

    ibss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ibss_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- sv/ibss_checker.sv -----
// Port-level checker for the IMU bias/smoothing block, bound to the top level
`include "imu_bias_smooth_scale_defines.svh"

module ibss_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input ibss_pkg::t_out o_out_data
);

    // handshake on the result side
    `IBSS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `IBSS_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_data), "stalled result changed")

    // one sample at a time: busy right after a transfer in
    `IBSS_ASSERT_NEXT(a_busy_after_in, i_in_valid && !o_in_stall, o_in_stall, "second sample taken while busy")

    // a new result only ever appears at the end of a busy stretch
    `IBSS_ASSERT_NOW(a_out_from_work, $rose(o_out_valid), $past(o_in_stall), "result without work")

endmodule

bind imu_bias_smooth_scale ibss_checker u_ibss_checker (.*);
